/* rtl/isu_pkg.sv */
// ----------------------------------------------------------------------------
// isu_pkg
// Transaction types shared by the insertion sorter unit and its cells.
// ----------------------------------------------------------------------------
package isu_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               set_end;
  } item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               run_end;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

/* rtl/isu_cell.sv */
// ----------------------------------------------------------------------------
// isu_cell
// One slot of the sorted chain: opens a gap or takes the new value on insert,
// takes its right neighbor's value on shift.
// ----------------------------------------------------------------------------
module isu_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  isu_pkg::cell_ctrl_t          ctrl,
  input  logic                         valid,
  input  logic signed [DATA_WIDTH-1:0] new_value,
  input  logic signed [DATA_WIDTH-1:0] left_data,
  input  logic                         left_greater,
  input  logic signed [DATA_WIDTH-1:0] right_data,
  output logic signed [DATA_WIDTH-1:0] data,
  output logic                         greater
);
  import isu_pkg::*;

  assign greater = !valid || (data > new_value);

  always_ff @(posedge clk) begin
    if (ctrl.insert && greater) begin
      data <= left_greater ? left_data : new_value;
    end else if (ctrl.shift) begin
      data <= right_data;
    end
  end

endmodule

/* rtl/insertion_sorter_unit.sv */
// ----------------------------------------------------------------------------
// insertion_sorter_unit
// Stable insertion sorter built as a chain of compare-and-shift cells.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   input   | start & !busy        | item   (value, set_end)
//   output  | strobe, one cycle    | result (sorted_value, run_end, overflow)
//
// One item is taken per cycle while idle; every cell compares against the
// new value at once. An item with set_end is followed by emission of every
// stored item, one result per cycle, shifted out of the head cell; busy is
// high throughout the emission. Reset clears the fill count, the overflow
// flag and the state; cell contents stay undefined. The receiver cannot
// stall the result stream.
// ----------------------------------------------------------------------------
module insertion_sorter_unit #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  isu_pkg::item_t   item,
  output logic             busy,
  output logic             strobe,
  output isu_pkg::result_t result
);
  import isu_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                         state;
  logic [CW-1:0]                count;
  logic                         dropped;
  logic                         accept;
  logic                         full;
  logic signed [DATA_WIDTH-1:0] new_value;
  cell_ctrl_t                   ctrl;

  logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_data;
  logic [DEPTH-1:0]                 cell_greater;

  assign busy      = (state == ST_EMIT);
  assign accept    = start && !busy;
  assign full      = (count == CW'(DEPTH));
  assign new_value = DATA_WIDTH'(item.value);
  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = (state == ST_EMIT);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_d;
    logic                         left_g;
    logic signed [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_head
      assign left_d = '0;
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_d = cell_data[i-1];
      assign left_g = cell_greater[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    isu_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (count > CW'(i)),
      .new_value   (new_value),
      .left_data   (left_d),
      .left_greater(left_g),
      .right_data  (right_d),
      .data        (cell_data[i]),
      .greater     (cell_greater[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            if (item.set_end) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          count <= count - CW'(1);
          if (count == CW'(1)) begin
            state   <= ST_IDLE;
            dropped <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign strobe              = (state == ST_EMIT);
  assign result.sorted_value = 32'($signed(cell_data[0]));
  assign result.run_end      = (count == CW'(1));
  assign result.overflow     = dropped;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for insertion_sorter_unit. Sets of signed values are sent one
// transaction at a time, in bursts with random gaps, and a shadow copy of the
// sorted store predicts every result of each set: ascending order with equal
// values kept in arrival order, run_end on the last result, and overflow on
// every result of a set that lost elements. Directed sets cover the extremes,
// duplicates, a single element, a full store and overflow; random sets follow.
// ----------------------------------------------------------------------------
module tb;
  import isu_pkg::*;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_GOAL   = 500;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  item_t   item  = '0;
  logic    busy;
  logic    strobe;
  result_t result;

  int      sorted_copy[$];
  logic    copy_dropped = 1'b0;
  result_t pending_sorted[$];

  int      mismatches = 0;
  int      cycle_count = 0;
  int      items_sent = 0;
  int      burst_left = 0;

  insertion_sorter_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic note_failure(input string msg);
    if (mismatches < 10) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Insert after equal values; on set end, queue the whole run in order.
  task automatic predict_sorted_run(input logic signed [31:0] v, input logic last);
    int      p;
    result_t r;
    if (sorted_copy.size() < DEPTH) begin
      p = sorted_copy.size();
      while (p > 0 && sorted_copy[p-1] > int'(v)) p--;
      sorted_copy.insert(p, int'(v));
    end else begin
      copy_dropped = 1'b1;
    end
    if (last) begin
      foreach (sorted_copy[i]) begin
        r.sorted_value = sorted_copy[i];
        r.run_end      = (i == sorted_copy.size() - 1);
        r.overflow     = copy_dropped;
        pending_sorted.push_back(r);
      end
      sorted_copy.delete();
      copy_dropped = 1'b0;
    end
  endtask

  task automatic send_item(input logic signed [31:0] v, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    item  <= '{value: v, set_end: last};
    do @(posedge clk); while (busy);
    predict_sorted_run(v, last);
    items_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: pick_value = $signed($urandom_range(0, 15)) - 8;
      3:       pick_value = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: pick_value = $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      if (pending_sorted.size() == 0) begin
        note_failure($sformatf("unexpected result value=%0d run_end=%0b overflow=%0b",
                               result.sorted_value, result.run_end, result.overflow));
      end else begin
        want = pending_sorted.pop_front();
        if (result.sorted_value !== want.sorted_value || result.run_end !== want.run_end ||
            result.overflow !== want.overflow)
          note_failure($sformatf(
            "mismatch: expected value=%0d run_end=%0b overflow=%0b, got %0d %0b %0b",
            want.sorted_value, want.run_end, want.overflow,
            result.sorted_value, result.run_end, result.overflow));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic test_extremes();
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(32'sh8000_0001, 1'b0);
    send_item(32'sh7FFF_FFFE, 1'b1);
  endtask

  task automatic test_single();
    send_item(32'sh8000_0000, 1'b1);
    send_item($urandom, 1'b1);
  endtask

  task automatic test_duplicates();
    send_item(5, 1'b0);
    send_item(-3, 1'b0);
    send_item(5, 1'b0);
    send_item(5, 1'b0);
    send_item(-3, 1'b0);
    send_item(0, 1'b0);
    send_item(5, 1'b1);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < DEPTH; i++) send_item(1000 - i * 37, i == DEPTH - 1);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < DEPTH + 5; i++) send_item(pick_value(), i == DEPTH + 4);
    for (int i = 0; i < DEPTH + 1; i++) send_item(pick_value(), i == DEPTH);
  endtask

  task automatic test_random_sets();
    int n;
    int sel;
    while (items_sent < ITEM_GOAL) begin
      sel = $urandom_range(0, 99);
      if (sel < 70)      n = $urandom_range(1, 8);
      else if (sel < 90) n = $urandom_range(9, 40);
      else if (sel < 97) n = $urandom_range(41, DEPTH);
      else               n = $urandom_range(DEPTH + 1, DEPTH + 8);
      for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_single();
    test_duplicates();
    test_full_store();
    test_overflow();
    test_random_sets();
    start <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/isu_pkg.sv
rtl/isu_cell.sv
rtl/insertion_sorter_unit.sv
tb/tb.sv
